[src/dkvis_pkg.sv]
// Shared constants and controller/datapath interface types for the insertion sorter.
package dkvis_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int KEY_BITS_DEF   = 32;
  localparam int KEY_FIELD_BITS = 32;
  localparam int PAYLOAD_BITS   = 32;
  localparam int IN_TDATA_BITS  = 64;
  localparam int OUT_TDATA_BITS = 64;
  localparam int OUT_TUSER_BITS = 1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the incoming pair
    logic pos_load;  // start the scan at the current fill count
    logic pos_dec;   // move the insertion point down one entry
    logic rd_out;    // read address comes from the output index
    logic rd_next;   // read the entry below the one just compared
    logic wr_en;     // write the store at the insertion point
    logic wr_new;    // write the new pair (else the entry just read)
    logic cnt_inc;   // one more entry stored
    logic cnt_clr;   // empty the store after output
    logic drop_set;  // note a dropped pair
    logic k_clr;     // restart the output index
    logic k_inc;     // advance the output index
    logic out_load;  // load the output register from the read data
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_one;
    logic less;
    logic last;
    logic k_last;
  } sts_t;

endpackage

[src/dkvis_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module dkvis_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write when enabled, read every cycle; the read data is registered and appears in the next cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[src/dkvis_datapath.sv]
// Datapath: input latch, fill count, scan pointer, sorted store and output register.
module dkvis_datapath #(
  parameter int CAPACITY = dkvis_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = dkvis_pkg::KEY_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dkvis_pkg::cmd_t                       cmd,
  output dkvis_pkg::sts_t                       sts,
  input  logic [dkvis_pkg::IN_TDATA_BITS-1:0]   in_tdata,
  input  logic                                  in_tlast,
  output logic [dkvis_pkg::OUT_TDATA_BITS-1:0]  out_tdata,
  output logic                                  out_tlast,
  output logic [dkvis_pkg::OUT_TUSER_BITS-1:0]  out_tuser
);
  import dkvis_pkg::*;

  localparam int KW = (KEY_BITS < KEY_FIELD_BITS) ? KEY_BITS : KEY_FIELD_BITS;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = KW + PAYLOAD_BITS;

  logic signed [KW-1:0]           new_key_r;
  logic [PAYLOAD_BITS-1:0]        new_pay_r;
  logic                           new_last_r;
  logic [CW-1:0]                  count_r;
  logic                           drop_r;
  logic [AW-1:0]                  pos_r;
  logic [AW-1:0]                  k_r;
  logic signed [KEY_FIELD_BITS-1:0] out_key_r;
  logic [PAYLOAD_BITS-1:0]        out_pay_r;
  logic                           out_last_r;
  logic                           out_ovf_r;

  logic [AW-1:0]                  rd_addr;
  logic [DW-1:0]                  wr_data;
  logic [DW-1:0]                  rd_data;
  logic signed [KW-1:0]           rd_key;
  logic [PAYLOAD_BITS-1:0]        rd_pay;
  logic                           k_last;

  // Latch the incoming pair, keeping only the significant key bits
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      new_key_r  <= in_tdata[KW-1:0];
      new_pay_r  <= in_tdata[KEY_FIELD_BITS +: PAYLOAD_BITS];
      new_last_r <= in_tlast;
    end
  end

  // Fill count, drop flag and output index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      drop_r  <= 1'b0;
      k_r     <= '0;
    end else begin
      if (cmd.cnt_clr) begin
        count_r <= '0;
      end else if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.cnt_clr) begin
        drop_r <= 1'b0;
      end else if (cmd.drop_set) begin
        drop_r <= 1'b1;
      end
      if (cmd.k_clr || cmd.cnt_clr) begin
        k_r <= '0;
      end else if (cmd.k_inc) begin
        k_r <= k_r + AW'(1);
      end
    end
  end

  // Insertion point walks down from the fill count
  always_ff @(posedge clk) begin
    if (cmd.pos_load) begin
      pos_r <= count_r[AW-1:0];
    end else if (cmd.pos_dec) begin
      pos_r <= pos_r - AW'(1);
    end
  end

  // Read the entry below the insertion point (or the one below that), or the next entry to emit
  always_comb begin
    if (cmd.rd_out) begin
      rd_addr = k_r;
    end else if (cmd.rd_next) begin
      rd_addr = pos_r - AW'(2);
    end else begin
      rd_addr = pos_r - AW'(1);
    end
  end

  assign wr_data = cmd.wr_new ? {new_pay_r, new_key_r} : rd_data;
  assign rd_key  = rd_data[KW-1:0];
  assign rd_pay  = rd_data[KW +: PAYLOAD_BITS];

  dkvis_ram #(
    .WIDTH(DW),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk    (clk),
    .wr_en  (cmd.wr_en),
    .wr_addr(pos_r),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign k_last = (CW'(k_r) == (count_r - CW'(1)));

  // Load the output register, sign-extending the key to the field width
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_key_r  <= KEY_FIELD_BITS'(rd_key);
      out_pay_r  <= rd_pay;
      out_last_r <= k_last;
      out_ovf_r  <= drop_r;
    end
  end

  // Status back to the controller
  always_comb begin
    sts.full    = (count_r == CW'(CAPACITY));
    sts.empty   = (count_r == '0);
    sts.pos_one = (pos_r == AW'(1));
    sts.less    = (rd_key < new_key_r);
    sts.last    = new_last_r;
    sts.k_last  = k_last;
  end

  assign out_tdata = {out_pay_r, out_key_r};
  assign out_tlast = out_last_r;
  assign out_tuser = out_ovf_r;

endmodule

[src/dkvis_ctrl.sv]
// Controller: sequences capture, insertion scan and output of the sorted batch.
module dkvis_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  dkvis_pkg::sts_t sts,
  output dkvis_pkg::cmd_t cmd
);
  import dkvis_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_PLACE,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_SEND
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r;
    cmd            = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          cmd.k_clr   = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.full) begin
          cmd.drop_set = 1'b1;
          state_nxt    = sts.last ? S_OUT_RD : S_IDLE;
        end else begin
          cmd.pos_load = 1'b1;
          state_nxt    = sts.empty ? S_PLACE : S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        // Shift a smaller entry up and fetch the next one below
        if (sts.less) begin
          cmd.wr_en   = 1'b1;
          cmd.pos_dec = 1'b1;
          cmd.rd_next = 1'b1;
          if (sts.pos_one) begin
            state_nxt = S_PLACE;
          end
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_new  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = sts.last ? S_OUT_RD : S_IDLE;
      end
      S_OUT_RD: begin
        cmd.rd_out = 1'b1;
        state_nxt  = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.out_load   = 1'b1;
        out_tvalid_nxt = 1'b1;
        state_nxt      = S_OUT_SEND;
      end
      S_OUT_SEND: begin
        cmd.rd_out = 1'b1;
        if (out_tready) begin
          out_tvalid_nxt = 1'b0;
          if (sts.k_last) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt      = S_IDLE;
        out_tvalid_nxt = 1'b0;
      end
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

endmodule

[src/descending_key_value_insertion_sort.sv]
// Insertion: capture, check, read, compare and shift, place; an empty store skips the scan.
// The scan shifts one store entry per cycle through the single write port of the RAM.
// Batch end: after insertion, each entry is read, loaded and sent, held while the output stalls.
// One transaction is in work at a time; input is taken again once the batch is emitted.
// Synchronous active-low reset clears the fill count, drop flag and controller state;
// store contents are not cleared, since only written entries are ever read.
module descending_key_value_insertion_sort #(
  parameter int CAPACITY = dkvis_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = dkvis_pkg::KEY_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [dkvis_pkg::IN_TDATA_BITS-1:0]  in_tdata,   // sort_key[31:0], payload[63:32]
  input  logic                                 in_tlast,   // batch_end
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [dkvis_pkg::OUT_TDATA_BITS-1:0] out_tdata,  // out_key[31:0], out_payload[63:32]
  output logic                                 out_tlast,  // final_entry
  output logic [dkvis_pkg::OUT_TUSER_BITS-1:0] out_tuser   // overflow[0]
);
  import dkvis_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dkvis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dkvis_datapath #(
    .CAPACITY(CAPACITY),
    .KEY_BITS(KEY_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tuser(out_tuser)
  );

endmodule

[dv/tb_descending_key_value_insertion_sort.sv]
// Self-checking testbench for the descending stable key/payload insertion sorter.
module tb_descending_key_value_insertion_sort;
  timeunit 1ns;
  timeprecision 1ps;

  import dkvis_pkg::*;

  localparam int STORE_DEPTH  = CAPACITY_DEF;
  localparam int CYCLE_LIMIT  = 600_000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int SETTLE_LIMIT = 50_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int MAX_PRINTS   = 100;

  typedef enum int {KEYS_ANY, KEYS_CLUSTERED, KEYS_EXTREME} key_mix_t;

  typedef struct {
    logic signed [KEY_FIELD_BITS-1:0] key;
    logic [PAYLOAD_BITS-1:0]          payload;
  } pair_t;

  typedef struct {
    logic signed [KEY_FIELD_BITS-1:0] key;
    logic [PAYLOAD_BITS-1:0]          payload;
    logic                             last_entry;
    logic                             overflow;
  } sorted_entry_t;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata   = '0;  // sort_key[31:0], payload[63:32]
  logic                      in_tlast   = 1'b0; // batch_end
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;        // out_key[31:0], out_payload[63:32]
  logic                      out_tlast;        // final_entry
  logic [OUT_TUSER_BITS-1:0] out_tuser;        // overflow[0]

  // Predicted store contents and the sorted entries still to come out
  pair_t         model_store[$];
  logic          model_dropped = 1'b0;
  sorted_entry_t pending_sorted[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;

  int mismatches       = 0;
  int pairs_accepted   = 0;
  int batches_done     = 0;
  int overflow_batches = 0;
  int entries_checked  = 0;
  int cycle_count      = 0;

  descending_key_value_insertion_sort dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d entries still expected", cycle_count,
               pending_sorted.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // Insert one pair behind all keys >= its own; on batch end emit the store in order
  function automatic void sort_insert(input pair_t p, input logic batch_end);
    int            pos;
    sorted_entry_t e;
    if (model_store.size() >= STORE_DEPTH) begin
      model_dropped = 1'b1;
    end else begin
      pos = model_store.size();
      while (pos > 0 && model_store[pos-1].key < p.key) pos--;
      model_store.insert(pos, p);
    end
    if (batch_end) begin
      foreach (model_store[i]) begin
        e.key        = model_store[i].key;
        e.payload    = model_store[i].payload;
        e.last_entry = (i == model_store.size() - 1);
        e.overflow   = model_dropped;
        pending_sorted.push_back(e);
      end
      batches_done++;
      if (model_dropped) overflow_batches++;
      model_store.delete();
      model_dropped = 1'b0;
    end
  endfunction

  // Check each output transaction, then predict from each input transaction
  always @(posedge clk) begin : monitor
    sorted_entry_t want;
    pair_t         got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        entries_checked++;
        if (pending_sorted.size() == 0) begin
          report_mismatch($sformatf("unexpected entry key %h payload %h",
                                    out_tdata[31:0], out_tdata[63:32]));
        end else begin
          want = pending_sorted.pop_front();
          if (out_tdata[31:0] !== want.key)
            report_mismatch($sformatf("key %h, want %h", out_tdata[31:0], want.key));
          if (out_tdata[63:32] !== want.payload)
            report_mismatch($sformatf("payload %h, want %h (key %h)", out_tdata[63:32],
                                      want.payload, want.key));
          if (out_tlast !== want.last_entry)
            report_mismatch($sformatf("final_entry %b, want %b (key %h)", out_tlast,
                                      want.last_entry, want.key));
          if (out_tuser[0] !== want.overflow)
            report_mismatch($sformatf("overflow %b, want %b (key %h)", out_tuser[0],
                                      want.overflow, want.key));
        end
      end
      if (in_tvalid && in_tready) begin
        got.key     = in_tdata[31:0];
        got.payload = in_tdata[63:32];
        pairs_accepted++;
        sort_insert(got, in_tlast);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen  <= hold_requests;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Offer one pair after a random gap and hold it until accepted
  task automatic send_pair(input logic [31:0] key, input logic [31:0] payload,
                           input logic batch_end);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {payload, key};
    in_tlast  <= batch_end;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [31:0] pick_key(input key_mix_t mix);
    case (mix)
      KEYS_CLUSTERED: begin
        // narrow range around zero, so ties are common
        return $urandom_range(0, 7) - 32'd4;
      end
      KEYS_EXTREME: begin
        case ($urandom_range(0, 5))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          4:       return 32'h0000_0001;
          default: return $urandom;
        endcase
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  task automatic send_random_batch(input int size, input key_mix_t mix);
    for (int i = 0; i < size; i++) send_pair(pick_key(mix), $urandom, i == size - 1);
  endtask

  // Key extremes, ties at both ends, one-pair batch, front insertion, stability
  task automatic test_directed_extremes();
    send_pair(32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
    send_pair(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_pair(32'h0000_0000, 32'hAAAA_AAAA, 1'b0);
    send_pair(32'hFFFF_FFFF, 32'h5555_5555, 1'b0);
    send_pair(32'h0000_0001, 32'h0000_0001, 1'b0);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_pair(32'h0000_0000, 32'h0000_0002, 1'b1);
    // single pair batch
    send_pair(32'h1234_5678, 32'hDEAD_BEEF, 1'b1);
    // ascending keys: every pair moves to the front
    for (int i = 0; i < 5; i++) send_pair(32'hFFFF_FFFE + i, 32'h100 + i, i == 4);
    // equal keys must come out in arrival order
    for (int i = 0; i < 6; i++) send_pair(32'h0000_0042, 32'h200 + i, i == 5);
  endtask

  // Exactly full; batch end meeting a full store; drops before the batch end
  task automatic test_full_store();
    send_random_batch(STORE_DEPTH, KEYS_ANY);
    send_random_batch(STORE_DEPTH + 1, KEYS_CLUSTERED);
    send_random_batch(STORE_DEPTH + 3, KEYS_EXTREME);
  endtask

  // Mostly short batches, a few long ones and a few that overflow
  task automatic test_random_batches(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int n_pairs);
    int       sent;
    int       size;
    int       pick;
    key_mix_t mix;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < n_pairs) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      size = $urandom_range(1, 8);
      else if (pick < 90) size = $urandom_range(9, 32);
      else if (pick < 97) size = $urandom_range(33, STORE_DEPTH);
      else                size = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 6);
      // keep the phase within its pair budget
      if (size > n_pairs - sent) size = n_pairs - sent;
      mix = key_mix_t'($urandom_range(0, 2));
      send_random_batch(size, mix);
      sent += size;
    end
  endtask

  // Block the output long enough that the next batch waits at the input
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests <= hold_requests + 1;
    send_random_batch(24, KEYS_ANY);
    send_random_batch(12, KEYS_CLUSTERED);
  endtask

  task automatic finish_run();
    int waited;
    in_tvalid <= 1'b0;
    recv_stall_pct = 0;
    waited = 0;
    while (pending_sorted.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_sorted.size() != 0)
      report_mismatch($sformatf("%0d sorted entries never came out", pending_sorted.size()));
    $display("sorted %0d pairs in %0d batches (%0d overflowed), %0d entries compared",
             pairs_accepted, batches_done, overflow_batches, entries_checked);
    $display("gaps and stalls on both sides plus one long output hold-off; %0d cycles",
             cycle_count);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_full_store();
    test_random_batches(0, 0, 20);
    test_random_batches(69, 0, 20);
    test_random_batches(0, 69, 20);
    test_random_batches(31, 31, 20);
    test_output_backpressure();
    finish_run();
  end

endmodule
